// File: rtl/v3au_pkg.sv
package v3au_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int LAT_DEF       = (32 + FRAC_BITS_DEF + 3) > 37 ? (32 + FRAC_BITS_DEF + 3) : 37;

	localparam logic [2:0] OP_ADD   = 3'd0;
	localparam logic [2:0] OP_SUB   = 3'd1;
	localparam logic [2:0] OP_CROSS = 3'd2;
	localparam logic [2:0] OP_DOT   = 3'd3;
	localparam logic [2:0] OP_SCALE = 3'd4;
	localparam logic [2:0] OP_DIV   = 3'd5;
	localparam logic [2:0] OP_NORM  = 3'd6;

	localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
		logic signed [31:0] bx;
		logic signed [31:0] by_comp;
		logic signed [31:0] bz;
		logic signed [31:0] scalar;
	} item_t;

	typedef struct packed {
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [31:0] rz;
		logic signed [31:0] rs;
		logic               saturated;
	} result_t;

	typedef struct packed {
		logic [2:0]         op;
		logic               neg;
		logic               dz;
		logic signed [31:0] a;
	} lane_side_t;

endpackage

// File: rtl/v3au_div.sv
module v3au_div #(
	parameter int NUM_W = 48
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [31:0]      den,
	output logic [NUM_W-1:0] quo
);

	logic [31:0]      rem_q [NUM_W];
	logic [NUM_W-1:0] num_q [NUM_W];
	logic [NUM_W-1:0] quo_q [NUM_W];
	logic [31:0]      den_q [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_st
		logic [31:0]      rem_in;
		logic [NUM_W-1:0] num_in;
		logic [NUM_W-1:0] quo_in;
		logic [31:0]      den_in;
		logic [32:0]      trial;
		logic             ge;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign num_in = num;
			assign quo_in = '0;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign num_in = num_q[k-1];
			assign quo_in = quo_q[k-1];
			assign den_in = den_q[k-1];
		end

		assign trial = {rem_in, num_in[NUM_W-1]};
		assign ge    = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? 32'(trial - {1'b0, den_in}) : trial[31:0];
				num_q[k] <= num_in << 1;
				quo_q[k] <= {quo_in[NUM_W-2:0], ge};
				den_q[k] <= den_in;
			end
		end
	end

	assign quo = quo_q[NUM_W-1];

endmodule

// File: rtl/v3au_sqrt.sv
module v3au_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] rad,
	output logic [31:0] root
);

	logic [33:0] rem_q  [32];
	logic [63:0] rad_q  [32];
	logic [31:0] root_q [32];

	for (genvar k = 0; k < 32; k++) begin : g_st
		logic [33:0] rem_in;
		logic [63:0] rad_in;
		logic [31:0] root_in;
		logic [35:0] cur;
		logic [35:0] trial;
		logic        ge;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign rad_in  = rad;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_q[k-1];
			assign rad_in  = rad_q[k-1];
			assign root_in = root_q[k-1];
		end

		assign cur   = {rem_in, rad_in[63:62]};
		assign trial = {2'b00, root_in, 2'b01};
		assign ge    = cur >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k]  <= ge ? 34'(cur - trial) : cur[33:0];
				rad_q[k]  <= rad_in << 2;
				root_q[k] <= {root_in[30:0], ge};
			end
		end
	end

	assign root = root_q[31];

endmodule

// File: rtl/v3au_lane.sv
module v3au_lane #(
	parameter int FRAC_BITS = v3au_pkg::FRAC_BITS_DEF,
	parameter int LAT       = v3au_pkg::LAT_DEF
) (
	input  logic               clk,
	input  logic               en,
	input  logic [2:0]         op,
	input  logic signed [31:0] a_i,
	input  logic signed [31:0] a_j,
	input  logic signed [31:0] a_k,
	input  logic signed [31:0] b_i,
	input  logic signed [31:0] b_j,
	input  logic signed [31:0] b_k,
	input  logic signed [31:0] s,
	output logic signed [63:0] prod,
	output logic signed [31:0] res,
	output logic               sat
);

	localparam int NUM_W = 32 + FRAC_BITS;
	localparam int PAD_F = LAT - 4;
	localparam int PAD_Q = LAT - 2 - NUM_W;
	localparam int PAD_S = LAT - 2;

	logic signed [31:0] p1, q1, p2, q2;
	logic signed [32:0] addsub;
	logic [31:0]        a_mag, d_mag;

	logic signed [31:0] p1_s1, q1_s1, p2_s1, q2_s1;
	logic signed [32:0] addsub_s1, addsub_s2;
	logic [NUM_W-1:0]   num_s1;
	logic [31:0]        den_s1;
	logic signed [63:0] m1_s2, m2_s2;

	v3au_pkg::lane_side_t side_s1;
	v3au_pkg::lane_side_t side_dl [PAD_S];

	logic signed [64:0] diff, sh;
	logic               mul_ov, add_ov;
	logic signed [31:0] mul_val, add_val;
	logic signed [31:0] fast_d;
	logic               fsat_d;
	logic [32:0]        fast_s3;
	logic [32:0]        fast_dl [PAD_F];

	logic [NUM_W-1:0]   quo;
	logic [NUM_W-1:0]   q_dl [PAD_Q];

	v3au_pkg::lane_side_t side_e;
	logic [NUM_W-1:0]   q_e;
	logic signed [31:0] res_d;
	logic               sat_d;

	always_comb begin
		p1 = '0;
		q1 = '0;
		p2 = '0;
		q2 = '0;
		case (op)
			v3au_pkg::OP_CROSS: begin
				p1 = a_j;
				q1 = b_k;
				p2 = a_k;
				q2 = b_j;
			end
			v3au_pkg::OP_DOT: begin
				p1 = a_i;
				q1 = b_i;
			end
			v3au_pkg::OP_SCALE: begin
				p1 = a_i;
				q1 = s;
			end
			v3au_pkg::OP_NORM: begin
				p1 = a_i;
				q1 = a_i;
			end
			default: ;
		endcase
	end

	assign addsub = (op == v3au_pkg::OP_SUB) ? 33'(a_i) - 33'(b_i) : 33'(a_i) + 33'(b_i);
	assign a_mag  = a_i[31] ? 32'(-a_i) : 32'(a_i);
	assign d_mag  = s[31] ? 32'(-s) : 32'(s);

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1        <= p1;
			q1_s1        <= q1;
			p2_s1        <= p2;
			q2_s1        <= q2;
			addsub_s1    <= addsub;
			num_s1       <= NUM_W'(a_mag) << FRAC_BITS;
			den_s1       <= d_mag;
			side_s1.op   <= op;
			side_s1.neg  <= a_i[31] ^ s[31];
			side_s1.dz   <= (s == 32'sd0);
			side_s1.a    <= a_i;
			m1_s2        <= 64'(p1_s1) * 64'(q1_s1);
			m2_s2        <= 64'(p2_s1) * 64'(q2_s1);
			addsub_s2    <= addsub_s1;
			side_dl[0]   <= side_s1;
			for (int k = 1; k < PAD_S; k++) side_dl[k] <= side_dl[k-1];
		end
	end

	assign prod = m1_s2;

	always_comb begin
		diff    = 65'(m1_s2) - 65'(m2_s2);
		sh      = diff >>> FRAC_BITS;
		mul_ov  = !((&sh[64:31]) || (~|sh[64:31]));
		mul_val = mul_ov ? (sh[64] ? v3au_pkg::S32_MIN : v3au_pkg::S32_MAX) : sh[31:0];
		add_ov  = addsub_s2[32] != addsub_s2[31];
		add_val = add_ov ? (addsub_s2[32] ? v3au_pkg::S32_MIN : v3au_pkg::S32_MAX)
			: addsub_s2[31:0];
		fast_d  = '0;
		fsat_d  = 1'b0;
		case (side_dl[0].op)
			v3au_pkg::OP_ADD, v3au_pkg::OP_SUB: begin
				fast_d = add_val;
				fsat_d = add_ov;
			end
			v3au_pkg::OP_CROSS, v3au_pkg::OP_SCALE: begin
				fast_d = mul_val;
				fsat_d = mul_ov;
			end
			default: ;
		endcase
	end

	v3au_div #(.NUM_W(NUM_W)) u_div (
		.clk (clk),
		.en  (en),
		.num (num_s1),
		.den (den_s1),
		.quo (quo)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			fast_s3    <= {fsat_d, fast_d};
			fast_dl[0] <= fast_s3;
			for (int k = 1; k < PAD_F; k++) fast_dl[k] <= fast_dl[k-1];
			q_dl[0]    <= quo;
			for (int k = 1; k < PAD_Q; k++) q_dl[k] <= q_dl[k-1];
		end
	end

	assign side_e = side_dl[PAD_S-1];
	assign q_e    = q_dl[PAD_Q-1];

	always_comb begin
		res_d = '0;
		sat_d = 1'b0;
		case (side_e.op)
			v3au_pkg::OP_ADD, v3au_pkg::OP_SUB, v3au_pkg::OP_CROSS, v3au_pkg::OP_SCALE: begin
				res_d = fast_dl[PAD_F-1][31:0];
				sat_d = fast_dl[PAD_F-1][32];
			end
			v3au_pkg::OP_DIV: begin
				if (side_e.dz) begin
					res_d = side_e.a;
				end else if (side_e.neg) begin
					if (q_e > NUM_W'(64'h8000_0000)) begin
						res_d = v3au_pkg::S32_MIN;
						sat_d = 1'b1;
					end else begin
						res_d = ~q_e[31:0] + 32'd1;
					end
				end else begin
					if (q_e > NUM_W'(64'h7fff_ffff)) begin
						res_d = v3au_pkg::S32_MAX;
						sat_d = 1'b1;
					end else begin
						res_d = q_e[31:0];
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res <= res_d;
			sat <= sat_d;
		end
	end

endmodule

// File: rtl/v3au_merge.sv
module v3au_merge #(
	parameter int FRAC_BITS = v3au_pkg::FRAC_BITS_DEF,
	parameter int LAT       = v3au_pkg::LAT_DEF
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [2:0]            op,
	input  logic signed [63:0]    prod_x,
	input  logic signed [63:0]    prod_y,
	input  logic signed [63:0]    prod_z,
	input  logic signed [31:0]    res_x,
	input  logic signed [31:0]    res_y,
	input  logic signed [31:0]    res_z,
	input  logic                  sat_x,
	input  logic                  sat_y,
	input  logic                  sat_z,
	output v3au_pkg::result_t     result_d
);

	localparam int PAD_D = LAT - 5;
	localparam int PAD_R = LAT - 36;

	logic [2:0]         op_dl [LAT-1];
	logic signed [65:0] dsum_s3;
	logic [63:0]        sq_s3;
	logic signed [65:0] dsh;
	logic               dov;
	logic signed [31:0] dot_s4;
	logic               dsat_s4;
	logic [32:0]        dot_dl [PAD_D];
	logic [31:0]        root;
	logic [31:0]        root_dl [PAD_R];
	logic [2:0]         op_e;
	logic [31:0]        root_e;
	logic signed [31:0] rs_d, rs_q;
	logic               rsat_d, rsat_q;

	assign dsh = dsum_s3 >>> FRAC_BITS;
	assign dov = !((&dsh[65:31]) || (~|dsh[65:31]));

	always_ff @(posedge clk) begin
		if (en) begin
			op_dl[0] <= op;
			for (int k = 1; k < LAT - 1; k++) op_dl[k] <= op_dl[k-1];
			dsum_s3 <= 66'(prod_x) + 66'(prod_y) + 66'(prod_z);
			sq_s3   <= $unsigned(prod_x) + $unsigned(prod_y) + $unsigned(prod_z);
			dot_s4  <= dov ? (dsh[65] ? v3au_pkg::S32_MIN : v3au_pkg::S32_MAX) : dsh[31:0];
			dsat_s4 <= dov;
			dot_dl[0] <= {dsat_s4, dot_s4};
			for (int k = 1; k < PAD_D; k++) dot_dl[k] <= dot_dl[k-1];
			root_dl[0] <= root;
			for (int k = 1; k < PAD_R; k++) root_dl[k] <= root_dl[k-1];
		end
	end

	v3au_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (sq_s3),
		.root (root)
	);

	assign op_e   = op_dl[LAT-2];
	assign root_e = root_dl[PAD_R-1];

	always_comb begin
		rs_d   = '0;
		rsat_d = 1'b0;
		case (op_e)
			v3au_pkg::OP_DOT: begin
				rs_d   = dot_dl[PAD_D-1][31:0];
				rsat_d = dot_dl[PAD_D-1][32];
			end
			v3au_pkg::OP_NORM: begin
				rs_d   = root_e[31] ? v3au_pkg::S32_MAX : root_e;
				rsat_d = root_e[31];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rs_q   <= rs_d;
			rsat_q <= rsat_d;
		end
	end

	assign result_d.rx        = res_x;
	assign result_d.ry        = res_y;
	assign result_d.rz        = res_z;
	assign result_d.rs        = rs_q;
	assign result_d.saturated = sat_x | sat_y | sat_z | rsat_q;

endmodule

// File: rtl/vector3_arithmetic_unit_core.sv
// Depth from an accepted word to its result word is set by the longer of the pipelined
// divider, which resolves one quotient bit per stage, and the square root. Throughput: one
// word per cycle; the output register plus one skid entry keep input open until the skid fills.
// Reset: arst_n clears all valid bits asynchronously; datapath registers are not reset.
module vector3_arithmetic_unit_core #(
	parameter int FRAC_BITS = v3au_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  v3au_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output v3au_pkg::result_t result
);

	localparam int NUM_W = 32 + FRAC_BITS;
	localparam int LAT   = ((NUM_W + 1) > 35 ? (NUM_W + 1) : 35) + 2;

	logic                 en;
	logic                 vld_q [LAT];
	logic signed [63:0]   prod_x, prod_y, prod_z;
	logic signed [31:0]   res_x, res_y, res_z;
	logic                 sat_x, sat_y, sat_z;
	v3au_pkg::result_t    result_d;
	v3au_pkg::result_t    out_q, skid_q;
	logic                 out_valid_q, skid_valid_q;
	logic                 incoming;
	logic                 out_free;

	assign en         = !skid_valid_q;
	assign item_stall = skid_valid_q;

	v3au_lane #(.FRAC_BITS(FRAC_BITS), .LAT(LAT)) u_lane_x (
		.clk (clk), .en (en), .op (item.op),
		.a_i (item.ax), .a_j (item.ay), .a_k (item.az),
		.b_i (item.bx), .b_j (item.by_comp), .b_k (item.bz),
		.s (item.scalar), .prod (prod_x), .res (res_x), .sat (sat_x)
	);

	v3au_lane #(.FRAC_BITS(FRAC_BITS), .LAT(LAT)) u_lane_y (
		.clk (clk), .en (en), .op (item.op),
		.a_i (item.ay), .a_j (item.az), .a_k (item.ax),
		.b_i (item.by_comp), .b_j (item.bz), .b_k (item.bx),
		.s (item.scalar), .prod (prod_y), .res (res_y), .sat (sat_y)
	);

	v3au_lane #(.FRAC_BITS(FRAC_BITS), .LAT(LAT)) u_lane_z (
		.clk (clk), .en (en), .op (item.op),
		.a_i (item.az), .a_j (item.ax), .a_k (item.ay),
		.b_i (item.bz), .b_j (item.bx), .b_k (item.by_comp),
		.s (item.scalar), .prod (prod_z), .res (res_z), .sat (sat_z)
	);

	v3au_merge #(.FRAC_BITS(FRAC_BITS), .LAT(LAT)) u_merge (
		.clk (clk), .en (en), .op (item.op),
		.prod_x (prod_x), .prod_y (prod_y), .prod_z (prod_z),
		.res_x (res_x), .res_y (res_y), .res_z (res_z),
		.sat_x (sat_x), .sat_y (sat_y), .sat_z (sat_z),
		.result_d (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) vld_q[k] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= item_valid;
			for (int k = 1; k < LAT; k++) vld_q[k] <= vld_q[k-1];
		end
	end

	assign incoming = en && vld_q[LAT-1];
	assign out_free = !out_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_free) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (out_free) begin
			out_valid_q <= incoming;
		end else if (incoming) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_free) out_q <= skid_q;
		end else if (out_free) begin
			if (incoming) out_q <= result_d;
		end else if (incoming) begin
			skid_q <= result_d;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

`ifndef NO_ASSERTIONS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without an output word");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && result_stall))
		else $error("skid filled while output was free");

	a_scalar_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.rs != 32'sd0) |->
		(result.rx == 32'sd0 && result.ry == 32'sd0 && result.rz == 32'sd0))
		else $error("scalar and vector results both nonzero");
`endif

endmodule

// File: test/vector3_arithmetic_unit_core_tb.sv
`timescale 1ns / 100ps

module vector3_arithmetic_unit_core_tb;

	localparam int FB = v3au_pkg::FRAC_BITS_DEF;
	localparam logic [2:0] OP_NONE = 3'd7;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 80;
	localparam int DIRECTED_ROWS = 21;
	localparam logic signed [31:0] VMAX = v3au_pkg::S32_MAX;
	localparam logic signed [31:0] VMIN = v3au_pkg::S32_MIN;
	localparam logic signed [95:0] WIDE_MAX = 96'sh7fff_ffff;
	localparam logic signed [95:0] WIDE_MIN = -96'sh8000_0000;

	typedef struct {
		v3au_pkg::item_t   word;
		bit                fixed;
		v3au_pkg::result_t want;
	} pending_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_stall;
	v3au_pkg::item_t   item = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	v3au_pkg::result_t result;

	pending_t          send_q[$];
	v3au_pkg::result_t expected_q[$];
	pending_t          directed [DIRECTED_ROWS];
	int                send_idle_pct = 0;
	int                recv_idle_pct = 0;
	bit                hold_send = 1'b0;
	int                errors = 0;
	int                words_in = 0;
	int                words_out = 0;
	int                sat_seen = 0;
	int                cycles = 0;

	vector3_arithmetic_unit_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic signed [31:0] clamp32(input logic signed [95:0] v, inout logic flag);
		if (v > WIDE_MAX) begin
			flag = 1'b1;
			return VMAX;
		end
		if (v < WIDE_MIN) begin
			flag = 1'b1;
			return VMIN;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [95:0] mul_wide(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [95:0] wa, wb;
		wa = 96'(a);
		wb = 96'(b);
		return wa * wb;
	endfunction

	function automatic logic [63:0] magnitude(input logic signed [31:0] v);
		logic signed [63:0] w;
		w = 64'(v);
		return (w < 0) ? 64'(-w) : 64'(w);
	endfunction

	function automatic logic signed [31:0] fix_quotient(input logic signed [31:0] a,
			input logic signed [31:0] d, inout logic flag);
		logic [63:0] q;
		logic        neg;
		q = (magnitude(a) << FB) / magnitude(d);
		neg = (a < 0) != (d < 0);
		if (neg) begin
			if (q > 64'h8000_0000) begin
				flag = 1'b1;
				q = 64'h8000_0000;
			end
			return -q[31:0];
		end
		if (q > 64'h7fff_ffff) begin
			flag = 1'b1;
			q = 64'h7fff_ffff;
		end
		return q[31:0];
	endfunction

	function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
		logic [63:0] root, place;
		root = 0;
		place = 64'h1 << 62;
		while (place > n) place = place >> 2;
		while (place != 0) begin
			if (n >= root + place) begin
				n = n - (root + place);
				root = (root >> 1) + place;
			end else begin
				root = root >> 1;
			end
			place = place >> 2;
		end
		return root;
	endfunction

	function automatic v3au_pkg::result_t vector_result(input v3au_pkg::item_t w);
		v3au_pkg::result_t  r;
		logic               f;
		logic signed [31:0] av[3], bv[3];
		logic signed [95:0] acc;
		logic [63:0]        sq, root;
		r = '0;
		f = 1'b0;
		av = '{w.ax, w.ay, w.az};
		bv = '{w.bx, w.by_comp, w.bz};
		case (w.op)
			v3au_pkg::OP_ADD: begin
				r.rx = clamp32(96'(av[0]) + 96'(bv[0]), f);
				r.ry = clamp32(96'(av[1]) + 96'(bv[1]), f);
				r.rz = clamp32(96'(av[2]) + 96'(bv[2]), f);
			end
			v3au_pkg::OP_SUB: begin
				r.rx = clamp32(96'(av[0]) - 96'(bv[0]), f);
				r.ry = clamp32(96'(av[1]) - 96'(bv[1]), f);
				r.rz = clamp32(96'(av[2]) - 96'(bv[2]), f);
			end
			v3au_pkg::OP_CROSS: begin
				r.rx = clamp32((mul_wide(av[1], bv[2]) - mul_wide(av[2], bv[1])) >>> FB, f);
				r.ry = clamp32((mul_wide(av[2], bv[0]) - mul_wide(av[0], bv[2])) >>> FB, f);
				r.rz = clamp32((mul_wide(av[0], bv[1]) - mul_wide(av[1], bv[0])) >>> FB, f);
			end
			v3au_pkg::OP_DOT: begin
				acc = mul_wide(av[0], bv[0]) + mul_wide(av[1], bv[1]) + mul_wide(av[2], bv[2]);
				r.rs = clamp32(acc >>> FB, f);
			end
			v3au_pkg::OP_SCALE: begin
				r.rx = clamp32(mul_wide(av[0], w.scalar) >>> FB, f);
				r.ry = clamp32(mul_wide(av[1], w.scalar) >>> FB, f);
				r.rz = clamp32(mul_wide(av[2], w.scalar) >>> FB, f);
			end
			v3au_pkg::OP_DIV: begin
				if (w.scalar == 0) begin
					r.rx = av[0];
					r.ry = av[1];
					r.rz = av[2];
				end else begin
					r.rx = fix_quotient(av[0], w.scalar, f);
					r.ry = fix_quotient(av[1], w.scalar, f);
					r.rz = fix_quotient(av[2], w.scalar, f);
				end
			end
			v3au_pkg::OP_NORM: begin
				sq = magnitude(av[0]) * magnitude(av[0]) + magnitude(av[1]) * magnitude(av[1])
					+ magnitude(av[2]) * magnitude(av[2]);
				root = floor_sqrt(sq);
				if (root > 64'h7fff_ffff) begin
					f = 1'b1;
					root = 64'h7fff_ffff;
				end
				r.rs = root[31:0];
			end
			default: ;
		endcase
		r.saturated = f;
		return r;
	endfunction

	function automatic v3au_pkg::item_t make_word(input logic [2:0] op,
			input logic signed [31:0] ax, input logic signed [31:0] ay,
			input logic signed [31:0] az, input logic signed [31:0] bx,
			input logic signed [31:0] by_c, input logic signed [31:0] bz,
			input logic signed [31:0] s);
		v3au_pkg::item_t w;
		w.op = op;
		w.ax = ax;
		w.ay = ay;
		w.az = az;
		w.bx = bx;
		w.by_comp = by_c;
		w.bz = bz;
		w.scalar = s;
		return w;
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(7))
			0: return VMAX;
			1: return VMIN;
			2: return 0;
			3: return $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
			4: return $signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_word(input v3au_pkg::item_t w, input bit fixed,
			input v3au_pkg::result_t want);
		pending_t p;
		p.word = w;
		p.fixed = fixed;
		p.want = want;
		send_q.push_back(p);
	endtask

	task automatic queue_random(input int count);
		for (int i = 0; i < count; i++) begin
			queue_word(make_word(3'($urandom_range(7)), pick_value(), pick_value(), pick_value(),
				pick_value(), pick_value(), pick_value(), pick_value()), 1'b0, '0);
		end
	endtask

	task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch on word %0d: %s got %h want %h", words_out, field, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		bit              drive;
		v3au_pkg::item_t next_word;
		drive = 1'b0;
		next_word = item;
		if (item_valid && !item_stall) begin
			pending_t p;
			p = send_q.pop_front();
			expected_q.push_back(p.fixed ? p.want : vector_result(p.word));
			words_in++;
		end
		if (item_valid && item_stall) begin
			drive = 1'b1;
		end else if (send_q.size() > 0 && !hold_send && arst_n
				&& $urandom_range(99) >= send_idle_pct) begin
			drive = 1'b1;
			next_word = send_q[0].word;
		end
		item_valid <= drive;
		item <= next_word;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
		if (result_valid && !result_stall) begin
			if (expected_q.size() == 0) begin
				$display("unexpected word %0d", words_out);
				errors++;
			end else begin
				v3au_pkg::result_t e;
				e = expected_q.pop_front();
				if (result.rx !== e.rx) report("rx", result.rx, e.rx);
				if (result.ry !== e.ry) report("ry", result.ry, e.ry);
				if (result.rz !== e.rz) report("rz", result.rz, e.rz);
				if (result.rs !== e.rs) report("rs", result.rs, e.rs);
				if (result.saturated !== e.saturated)
					report("saturated", 32'(result.saturated), 32'(e.saturated));
				if (e.saturated) sat_seen++;
			end
			words_out++;
		end
		result_stall <= arst_n && ($urandom_range(99) < recv_idle_pct);
	end

	task automatic wait_drained();
		while (send_q.size() > 0 || item_valid || expected_q.size() > 0) @(posedge clk);
	endtask

	initial begin
		directed = '{
			'{make_word(v3au_pkg::OP_ADD, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0},
			'{make_word(v3au_pkg::OP_ADD, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, 0),
				1'b1, '{VMAX, VMAX, VMAX, 0, 1'b1}},
			'{make_word(v3au_pkg::OP_SUB, VMIN, VMIN, VMIN, VMAX, VMAX, VMAX, 0),
				1'b1, '{VMIN, VMIN, VMIN, 0, 1'b1}},
			'{make_word(v3au_pkg::OP_ADD, VMAX, VMIN, -1, 1, -1, 1, 5), 1'b0, '0},
			'{make_word(v3au_pkg::OP_SUB, 7, -9, 32'sh0001_0000, 3, 4, -5, 0), 1'b0, '0},
			'{make_word(v3au_pkg::OP_CROSS, 32'sh0001_0000, 0, 0, 0, 32'sh0001_0000, 0, 0),
				1'b0, '0},
			'{make_word(v3au_pkg::OP_CROSS, VMIN, VMAX, VMIN, VMAX, VMIN, VMIN, 0), 1'b0, '0},
			'{make_word(v3au_pkg::OP_DOT, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, 0),
				1'b1, '{0, 0, 0, VMAX, 1'b1}},
			'{make_word(v3au_pkg::OP_DOT, VMIN, VMIN, VMIN, VMAX, VMAX, VMAX, 0), 1'b0, '0},
			'{make_word(v3au_pkg::OP_DOT, -3, 5, 32'sh0002_0000, 1, -1, 32'sh0000_8000, 0),
				1'b0, '0},
			'{make_word(v3au_pkg::OP_SCALE, 5, -5, VMAX, 0, 0, 0, 32'sh0001_0000), 1'b0, '0},
			'{make_word(v3au_pkg::OP_SCALE, VMIN, VMAX, -1, 0, 0, 0, VMIN), 1'b0, '0},
			'{make_word(v3au_pkg::OP_SCALE, -1, 1, 3, 0, 0, 0, 32'sh0000_8000), 1'b0, '0},
			'{make_word(v3au_pkg::OP_DIV, 123, -5, VMIN, 9, 9, 9, 0),
				1'b1, '{123, -5, VMIN, 0, 1'b0}},
			'{make_word(v3au_pkg::OP_DIV, VMIN, VMAX, 0, 0, 0, 0, -1), 1'b0, '0},
			'{make_word(v3au_pkg::OP_DIV, VMIN, -7, 7, 0, 0, 0, VMAX), 1'b0, '0},
			'{make_word(v3au_pkg::OP_DIV, 32'sh0003_0000, -32'sh0003_0000, 1, 0, 0, 0,
				32'sh0002_0000), 1'b0, '0},
			'{make_word(v3au_pkg::OP_NORM, VMIN, VMIN, VMIN, 0, 0, 0, 0),
				1'b1, '{0, 0, 0, VMAX, 1'b1}},
			'{make_word(v3au_pkg::OP_NORM, 3, -4, 0, 0, 0, 0, 0), 1'b1, '{0, 0, 0, 5, 1'b0}},
			'{make_word(v3au_pkg::OP_NORM, VMAX, 0, 0, 1, 1, 1, 1), 1'b0, '0},
			'{make_word(OP_NONE, VMAX, VMIN, -1, VMAX, VMIN, -1, VMIN), 1'b1, '0}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			queue_word(directed[i].word, directed[i].fixed, directed[i].want);
		end

		send_idle_pct = 24;
		recv_idle_pct = 45;
		queue_random(560);
		wait_drained();

		send_idle_pct = 45;
		recv_idle_pct = 24;
		queue_random(280);
		@(posedge clk);
		while (send_q.size() > 140) @(posedge clk);
		// hold the sender until the pipeline empties out
		hold_send = 1'b1;
		while (item_valid || expected_q.size() > 0) @(posedge clk);
		hold_send = 1'b0;
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(840);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d words in, %0d words out, %0d saturated, over three idle mixes",
			words_in, words_out, sat_seen);
		$display("all seven operations plus the unused code, extremes and zero divisors");
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
